### hw/rtl/lpp_pkg.sv
package lpp_pkg;

    // Item kinds carried in the slave-side tuser
    typedef enum logic [2:0] {
        MODE_TICK       = 3'd0,
        MODE_READ_WORD  = 3'd1,
        MODE_READ_BYTE  = 3'd2,
        MODE_WRITE_WORD = 3'd3,
        MODE_WRITE_BYTE = 3'd4,
        MODE_IRQ_ACK    = 3'd5
    } t_mode;

    // Default register addresses (byte addresses, even)
    localparam logic [15:0] STATUS_ADDRESS_DEF = 16'd65356;
    localparam logic [15:0] BUFFER_ADDRESS_DEF = 16'd65358;

    // Print delay after reset, in instructions
    localparam logic [15:0] PRINT_DELAY_RESET = 16'd100;

    // Status word bit positions and masks
    localparam int          DONE_BIT  = 7;
    localparam int          IE_BIT    = 6;
    localparam logic [15:0] LOW_BYTE  = 16'o000377;
    localparam logic [15:0] HIGH_BYTE = 16'o177400;

    // Field widths
    localparam int TIME_W = 48;
    localparam int CHAR_W = 7;

    // Stream widths
    localparam int IN_TDATA_W  = 88;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 32;

endpackage

### hw/rtl/line_printer_port.sv
// Line printer port: a status/buffer register pair with a character sink and a print deadline.
// Each request on the slave stream is a tick, a word or byte read, a word or byte write, or an
// interrupt acknowledge, and yields exactly one result on the master stream. The block takes
// one request per cycle while the result side is not stalled; a request is held in the input
// register, and its result is then captured into the result register. The state update for a
// request happens as it moves into the result register, so the next request in the following
// cycle already sees it. The print deadline add and its compare against the instruction count
// sit in the one stage between the input register and the result register.
// The print delay is written through the cfg channel, which is always ready; write it only
// while no request is in flight.
module line_printer_port #(
    parameter logic [15:0] STATUS_ADDRESS = lpp_pkg::STATUS_ADDRESS_DEF,
    parameter logic [15:0] BUFFER_ADDRESS = lpp_pkg::BUFFER_ADDRESS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write: print_delay
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [15:0]                         i_cfg_data,
    // Request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: addr[15:0], wdata[31:16], now[79:32], sink_ready[80], zero fill [87:81]
    input  logic [lpp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: mode[2:0]
    input  logic [lpp_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: rdata[15:0], hit[16], char_valid[17], char_code[24:18], irq_request[25],
    //        irq_taken[26], ready_flag[27], zero fill [31:28]
    output logic [lpp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int TW = lpp_pkg::TIME_W;
    localparam int CW = lpp_pkg::CHAR_W;

    // Configuration and device state
    logic [15:0]   r_print_delay;
    logic          r_done, n_done;
    logic          r_enable, n_enable;
    logic          r_irq, n_irq;
    logic [TW-1:0] r_deadline, n_deadline;
    logic          r_stash_valid, n_stash_valid;
    logic [CW-1:0] r_stash_char, n_stash_char;

    // Input register
    logic          r_in_valid;
    lpp_pkg::t_mode r_in_mode;
    logic [15:0]   r_in_addr;
    logic [15:0]   r_in_wdata;
    logic [TW-1:0] r_in_now;
    logic          r_in_sink_ready;

    // Result register
    logic          r_out_valid;
    logic [15:0]   r_out_rdata, n_rdata;
    logic          r_out_hit, n_hit;
    logic          r_out_char_valid, n_char_valid;
    logic [CW-1:0] r_out_char_code, n_char_code;
    logic          r_out_irq_taken, n_irq_taken;
    logic          r_out_irq, r_out_done;

    logic          advance;
    logic          in_take;

    // Decode and helpers
    logic          is_status, is_buffer;
    logic [15:0]   status_word, bus_word, write_value;
    logic [TW:0]   deadline_sum;
    logic [TW-1:0] deadline_new;
    logic [CW-1:0] write_char;
    logic          stash_blocked;

    assign o_cfg_ready   = 1'b1;
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Address decode ignores bit 0
    assign is_status   = (r_in_addr[15:1] == STATUS_ADDRESS[15:1]);
    assign is_buffer   = (r_in_addr[15:1] == BUFFER_ADDRESS[15:1]);
    assign status_word = {8'd0, r_done, r_enable, 6'd0};
    assign bus_word    = is_status ? status_word : 16'd0;

    // Byte writes merge into the word as a read returns it
    always_comb begin
        if (r_in_mode == lpp_pkg::MODE_WRITE_BYTE) begin
            if (r_in_addr[0]) begin
                write_value = {r_in_wdata[7:0], bus_word[7:0]};
            end else begin
                write_value = (bus_word & lpp_pkg::HIGH_BYTE)
                            | (r_in_wdata & lpp_pkg::LOW_BYTE);
            end
        end else begin
            write_value = r_in_wdata;
        end
    end
    assign write_char = write_value[CW-1:0];

    // Deadline for a character taken now: saturate, and never store zero
    assign deadline_sum = {1'b0, r_in_now} + {{(TW+1-16){1'b0}}, r_print_delay};
    always_comb begin
        if (deadline_sum[TW]) begin
            deadline_new = {TW{1'b1}};
        end else if (deadline_sum[TW-1:0] == '0) begin
            deadline_new = {{(TW-1){1'b0}}, 1'b1};
        end else begin
            deadline_new = deadline_sum[TW-1:0];
        end
    end

    // Next state and result for the request in the input register
    always_comb begin
        n_done        = r_done;
        n_enable      = r_enable;
        n_irq         = r_irq;
        n_deadline    = r_deadline;
        n_stash_valid = r_stash_valid;
        n_stash_char  = r_stash_char;
        n_rdata       = 16'd0;
        n_hit         = 1'b0;
        n_char_valid  = 1'b0;
        n_char_code   = '0;
        n_irq_taken   = 1'b0;
        stash_blocked = 1'b0;

        case (r_in_mode)
            lpp_pkg::MODE_TICK: begin
                // Retry a stashed character first
                if (r_stash_valid) begin
                    if (r_in_sink_ready) begin
                        n_char_valid  = 1'b1;
                        n_char_code   = r_stash_char;
                        n_deadline    = deadline_new;
                        n_stash_valid = 1'b0;
                    end else begin
                        stash_blocked = 1'b1;
                    end
                end
                // Set done once the deadline is reached
                if (!stash_blocked && !r_done && n_deadline != '0
                        && r_in_now >= n_deadline) begin
                    n_done     = 1'b1;
                    n_deadline = '0;
                    if (r_enable) begin
                        n_irq = 1'b1;
                    end
                end
            end
            lpp_pkg::MODE_READ_WORD: begin
                n_hit   = is_status || is_buffer;
                n_rdata = bus_word;
            end
            lpp_pkg::MODE_READ_BYTE: begin
                n_hit   = is_status || is_buffer;
                n_rdata = r_in_addr[0] ? {8'd0, bus_word[15:8]}
                                       : (bus_word & lpp_pkg::LOW_BYTE);
            end
            lpp_pkg::MODE_WRITE_WORD, lpp_pkg::MODE_WRITE_BYTE: begin
                n_hit = is_status || is_buffer;
                if (is_status) begin
                    n_enable = write_value[lpp_pkg::IE_BIT];
                    if (!write_value[lpp_pkg::IE_BIT]) begin
                        n_irq = 1'b0;
                    end else if (!r_enable && r_done) begin
                        n_irq = 1'b1;
                    end
                end else if (is_buffer) begin
                    n_done = 1'b0;
                    n_irq  = 1'b0;
                    if (r_in_sink_ready) begin
                        n_char_valid = 1'b1;
                        n_char_code  = write_char;
                        n_deadline   = deadline_new;
                    end else begin
                        n_stash_valid = 1'b1;
                        n_stash_char  = write_char;
                        n_deadline    = '0;
                    end
                end
            end
            lpp_pkg::MODE_IRQ_ACK: begin
                n_irq_taken = r_irq;
                n_irq       = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Hold the print delay
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_print_delay <= lpp_pkg::PRINT_DELAY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_print_delay <= i_cfg_data;
        end
    end

    // Advance device state as a request moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done        <= 1'b1;
            r_enable      <= 1'b0;
            r_irq         <= 1'b0;
            r_deadline    <= '0;
            r_stash_valid <= 1'b0;
            r_stash_char  <= '0;
        end else if (advance) begin
            r_done        <= n_done;
            r_enable      <= n_enable;
            r_irq         <= n_irq;
            r_deadline    <= n_deadline;
            r_stash_valid <= n_stash_valid;
            r_stash_char  <= n_stash_char;
        end
    end

    // Input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Capture a request
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode       <= lpp_pkg::t_mode'(s_axis_tuser[2:0]);
            r_in_addr       <= s_axis_tdata[15:0];
            r_in_wdata      <= s_axis_tdata[31:16];
            r_in_now        <= s_axis_tdata[79:32];
            r_in_sink_ready <= s_axis_tdata[80];
        end
    end

    // Result register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Capture a result
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_rdata      <= n_rdata;
            r_out_hit        <= n_hit;
            r_out_char_valid <= n_char_valid;
            r_out_char_code  <= n_char_code;
            r_out_irq        <= n_irq;
            r_out_irq_taken  <= n_irq_taken;
            r_out_done       <= n_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_done, r_out_irq_taken, r_out_irq, r_out_char_code,
                            r_out_char_valid, r_out_hit, r_out_rdata};

endmodule

### hw/rtl/lpp_checker.sv
module lpp_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lpp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Requests back up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request side stalled with no result waiting");

    // An acknowledge that took an interrupt leaves none pending
    a_ack_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[26] |-> !m_axis_tdata[25])
        else $error("interrupt still pending after acknowledge");

    // No character code without a character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[17] |-> m_axis_tdata[24:18] == 7'd0)
        else $error("character code without a character");

endmodule

bind line_printer_port lpp_checker u_lpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### dv/lpp_checker.sv
module lpp_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [15:0]                       i_cfg_data,
    input  logic                              i_req_valid,
    input  logic                              i_req_ready,
    // addr[15:0], wdata[31:16], now[79:32], sink_ready[80]
    input  logic [lpp_pkg::IN_TDATA_W-1:0]    i_req_data,
    // mode[2:0]
    input  logic [lpp_pkg::IN_TUSER_W-1:0]    i_req_kind,
    input  logic                              i_res_valid,
    input  logic                              i_res_ready,
    // rdata[15:0], hit[16], char_valid[17], char_code[24:18], irq_request[25],
    // irq_taken[26], ready_flag[27]
    input  logic [lpp_pkg::OUT_TDATA_W-1:0]   i_res_data,
    output int                                o_fail_count,
    output int                                o_outstanding
);

    // One result word, rdata in the lowest bits
    typedef struct packed {
        logic                       ready_flag;
        logic                       irq_taken;
        logic                       irq_request;
        logic [lpp_pkg::CHAR_W-1:0] char_code;
        logic                       char_valid;
        logic                       hit;
        logic [15:0]                rdata;
    } t_port_result;

    // Shadow copy of the device registers
    logic [15:0]                delay_setting;
    logic                       printer_done;
    logic                       int_enable;
    logic                       int_pending;
    logic [lpp_pkg::TIME_W-1:0] due_count;
    logic                       held_valid;
    logic [lpp_pkg::CHAR_W-1:0] held_char;

    t_port_result      awaited_results[$];
    int                mismatch_count;

    assign o_fail_count  = mismatch_count;
    assign o_outstanding = awaited_results.size();

    initial mismatch_count = 0;

    function automatic logic [15:0] register_word(input logic [15:0] word_addr);
        logic [15:0] w;
        w = '0;
        if (word_addr == lpp_pkg::STATUS_ADDRESS_DEF) begin
            w[lpp_pkg::DONE_BIT] = printer_done;
            w[lpp_pkg::IE_BIT]   = int_enable;
        end
        return w;
    endfunction

    // Hand a character to the sink and arm the print deadline (saturating, never 0)
    task automatic hand_to_sink(input logic [lpp_pkg::CHAR_W-1:0] c,
                                input logic [lpp_pkg::TIME_W-1:0] now_v,
                                inout t_port_result r);
        logic [lpp_pkg::TIME_W:0] sum;
        r.char_valid = 1'b1;
        r.char_code  = c;
        sum = {1'b0, now_v} + {{(lpp_pkg::TIME_W-15){1'b0}}, delay_setting};
        if (sum[lpp_pkg::TIME_W])
            due_count = '1;
        else if (sum[lpp_pkg::TIME_W-1:0] == '0)
            due_count = 48'd1;
        else
            due_count = sum[lpp_pkg::TIME_W-1:0];
    endtask

    task automatic write_register(input logic [15:0] word_addr, input logic [15:0] v,
                                  input logic [lpp_pkg::TIME_W-1:0] now_v,
                                  input logic sink_rdy, inout t_port_result r);
        logic was_enabled;
        was_enabled = int_enable;
        if (word_addr == lpp_pkg::STATUS_ADDRESS_DEF) begin
            int_enable = v[lpp_pkg::IE_BIT];
            if (!int_enable)
                int_pending = 1'b0;
            if (!was_enabled && int_enable && printer_done)
                int_pending = 1'b1;
        end else if (word_addr == lpp_pkg::BUFFER_ADDRESS_DEF) begin
            printer_done = 1'b0;
            int_pending  = 1'b0;
            if (sink_rdy) begin
                hand_to_sink(v[lpp_pkg::CHAR_W-1:0], now_v, r);
            end else begin
                held_valid = 1'b1;
                held_char  = v[lpp_pkg::CHAR_W-1:0];
                due_count  = '0;
            end
        end
    endtask

    // Retry a held character, then check the deadline
    task automatic run_tick(input logic [lpp_pkg::TIME_W-1:0] now_v, input logic sink_rdy,
                            inout t_port_result r);
        logic blocked;
        blocked = 1'b0;
        if (held_valid) begin
            if (sink_rdy) begin
                hand_to_sink(held_char, now_v, r);
                held_valid = 1'b0;
            end else begin
                blocked = 1'b1;
            end
        end
        if (!blocked && !printer_done && due_count != '0 && now_v >= due_count) begin
            printer_done = 1'b1;
            due_count    = '0;
            if (int_enable)
                int_pending = 1'b1;
        end
    endtask

    task automatic predict_port_result(input logic [2:0] mode, input logic [15:0] addr,
                                       input logic [15:0] wdata,
                                       input logic [lpp_pkg::TIME_W-1:0] now_v,
                                       input logic sink_rdy, output t_port_result r);
        logic [15:0] word_addr;
        logic [15:0] w;
        logic [15:0] b;
        r = '0;
        word_addr = {addr[15:1], 1'b0};
        case (mode)
            lpp_pkg::MODE_TICK: begin
                run_tick(now_v, sink_rdy, r);
            end
            lpp_pkg::MODE_READ_WORD: begin
                r.rdata = register_word(word_addr);
            end
            lpp_pkg::MODE_READ_BYTE: begin
                w = register_word(word_addr);
                r.rdata = addr[0] ? (w >> 8) : (w & lpp_pkg::LOW_BYTE);
            end
            lpp_pkg::MODE_WRITE_WORD: begin
                write_register(word_addr, wdata, now_v, sink_rdy, r);
            end
            lpp_pkg::MODE_WRITE_BYTE: begin
                w = register_word(word_addr);
                b = {8'd0, wdata[7:0]};
                if (addr[0])
                    w = (w & lpp_pkg::LOW_BYTE) | (b << 8);
                else
                    w = (w & lpp_pkg::HIGH_BYTE) | b;
                write_register(word_addr, w, now_v, sink_rdy, r);
            end
            lpp_pkg::MODE_IRQ_ACK: begin
                if (int_pending) begin
                    int_pending = 1'b0;
                    r.irq_taken = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.hit = (mode >= lpp_pkg::MODE_READ_WORD && mode <= lpp_pkg::MODE_WRITE_BYTE) &&
                (word_addr == lpp_pkg::STATUS_ADDRESS_DEF ||
                 word_addr == lpp_pkg::BUFFER_ADDRESS_DEF);
        r.irq_request = int_pending;
        r.ready_flag  = printer_done;
    endtask

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] seen);
        if (want !== seen) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatch_count++;
        end
    endtask

    // Track config writes, predict each request, compare each result
    always @(posedge i_clk) begin
        t_port_result want;
        t_port_result seen;
        if (!i_rst_n) begin
            delay_setting = lpp_pkg::PRINT_DELAY_RESET;
            printer_done  = 1'b1;
            int_enable    = 1'b0;
            int_pending   = 1'b0;
            due_count     = '0;
            held_valid    = 1'b0;
            held_char     = '0;
            awaited_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                delay_setting = i_cfg_data;
            if (i_req_valid && i_req_ready) begin
                predict_port_result(i_req_kind, i_req_data[15:0], i_req_data[31:16],
                                    i_req_data[79:32], i_req_data[80], want);
                awaited_results.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                seen = t_port_result'(i_res_data[27:0]);
                if (awaited_results.size() == 0) begin
                    $error("result 0x%0h arrived with no request outstanding", i_res_data);
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    compare_field("rdata", want.rdata, seen.rdata);
                    compare_field("hit", want.hit, seen.hit);
                    compare_field("char_valid", want.char_valid, seen.char_valid);
                    compare_field("char_code", want.char_code, seen.char_code);
                    compare_field("irq_request", want.irq_request, seen.irq_request);
                    compare_field("irq_taken", want.irq_taken, seen.irq_taken);
                    compare_field("ready_flag", want.ready_flag, seen.ready_flag);
                end
            end
        end
    end

endmodule

### dv/tb_line_printer_port.sv
module tb_line_printer_port;

    localparam int          CYCLE_LIMIT   = 200000;
    // Kinds the block leaves undecoded
    localparam logic [2:0]  MODE_SPARE_6  = 3'd6;
    localparam logic [2:0]  MODE_SPARE_7  = 3'd7;
    localparam logic [47:0] INSTR_MAX     = 48'hFFFF_FFFF_FFFF;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [15:0]                     i_cfg_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lpp_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [lpp_pkg::IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lpp_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    int                     fail_count;
    int                     outstanding;
    int                     elapsed_cycles = 0;
    int                     sender_idle_pct = 0;
    int                     receiver_stall_pct = 0;
    logic [47:0]            instr_count = 48'd5000;

    line_printer_port uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lpp_scoreboard scoreboard (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (s_axis_tvalid),
        .i_req_ready   (s_axis_tready),
        .i_req_data    (s_axis_tdata),
        .i_req_kind    (s_axis_tuser),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Give up on a hung run
    always @(posedge i_clk) begin
        elapsed_cycles <= elapsed_cycles + 1;
        if (elapsed_cycles == CYCLE_LIMIT) begin
            $display("line_printer_port: mismatch");
            $finish;
        end
    end

    // Present one request, idling first at random, and hold it until taken
    task automatic send_request(input logic [2:0] mode, input logic [15:0] addr,
                                input logic [15:0] wdata, input logic [47:0] now_v,
                                input logic sink_rdy);
        int gap;
        gap = 0;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, sink_rdy, now_v, wdata, addr};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Mostly creep forward so deadlines get reached; sometimes jump around
    task automatic advance_instr_count();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            instr_count = 48'({$urandom, $urandom});
        else if (pick < 5)
            instr_count = INSTR_MAX - $urandom_range(200);
        else if (pick < 7)
            instr_count = '0;
        else if (pick < 17)
            instr_count = instr_count + $urandom_range(70000);
        else
            instr_count = instr_count + $urandom_range(40);
    endtask

    task automatic send_random_request();
        int          pick;
        logic [2:0]  mode;
        logic [15:0] addr;
        pick = $urandom_range(99);
        if (pick < 35)
            mode = lpp_pkg::MODE_TICK;
        else if (pick < 45)
            mode = lpp_pkg::MODE_READ_WORD;
        else if (pick < 53)
            mode = lpp_pkg::MODE_READ_BYTE;
        else if (pick < 73)
            mode = lpp_pkg::MODE_WRITE_WORD;
        else if (pick < 83)
            mode = lpp_pkg::MODE_WRITE_BYTE;
        else if (pick < 95)
            mode = lpp_pkg::MODE_IRQ_ACK;
        else
            mode = $urandom_range(1) ? MODE_SPARE_7 : MODE_SPARE_6;
        pick = $urandom_range(9);
        if (pick < 4)
            addr = lpp_pkg::STATUS_ADDRESS_DEF | 16'($urandom_range(1));
        else if (pick < 8)
            addr = lpp_pkg::BUFFER_ADDRESS_DEF | 16'($urandom_range(1));
        else
            addr = 16'($urandom);
        advance_instr_count();
        send_request(mode, addr, 16'($urandom), instr_count, $urandom_range(99) < 70);
    endtask

    // Drop valid and wait for every outstanding result, plus the pipeline depth
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_print_delay(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [15:0] delay_v, input int idle_pct,
                             input int stall_pct);
        drain();
        write_print_delay(delay_v);
        sender_idle_pct = idle_pct;
        receiver_stall_pct <= stall_pct;
        repeat (175) send_random_request();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reads from reset
        send_request(lpp_pkg::MODE_READ_WORD, lpp_pkg::STATUS_ADDRESS_DEF, 16'h0000,
                     48'd1000, 1'b1);
        send_request(lpp_pkg::MODE_READ_BYTE, lpp_pkg::STATUS_ADDRESS_DEF, 16'h0000,
                     48'd1000, 1'b1);
        send_request(lpp_pkg::MODE_READ_BYTE, lpp_pkg::STATUS_ADDRESS_DEF | 16'd1, 16'h0000,
                     48'd1000, 1'b1);
        send_request(lpp_pkg::MODE_READ_WORD, lpp_pkg::BUFFER_ADDRESS_DEF, 16'h0000,
                     48'd1000, 1'b1);
        // Enable while done raises an interrupt; ack it twice
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::STATUS_ADDRESS_DEF, 16'h0040,
                     48'd1000, 1'b1);
        send_request(lpp_pkg::MODE_IRQ_ACK, 16'h0000, 16'h0000, 48'd1000, 1'b1);
        send_request(lpp_pkg::MODE_IRQ_ACK, 16'h0000, 16'h0000, 48'd1000, 1'b1);
        // Print, tick before and at the deadline
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::BUFFER_ADDRESS_DEF, 16'hFFC1,
                     48'd1000, 1'b1);
        send_request(lpp_pkg::MODE_TICK, 16'h0000, 16'h0000, 48'd1099, 1'b1);
        send_request(lpp_pkg::MODE_TICK, 16'h0000, 16'h0000, 48'd1100, 1'b1);
        // Sink busy: hold the character, retry on ticks
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::BUFFER_ADDRESS_DEF, 16'h0042,
                     48'd1150, 1'b0);
        send_request(lpp_pkg::MODE_TICK, 16'h0000, 16'h0000, 48'd1160, 1'b0);
        send_request(lpp_pkg::MODE_TICK, 16'h0000, 16'h0000, 48'd1200, 1'b1);
        // Write while a character is held keeps the held one
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::BUFFER_ADDRESS_DEF, 16'h0043,
                     48'd1210, 1'b0);
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::BUFFER_ADDRESS_DEF, 16'h0044,
                     48'd1220, 1'b1);
        // High byte of the buffer sends character 0
        send_request(lpp_pkg::MODE_WRITE_BYTE, lpp_pkg::BUFFER_ADDRESS_DEF | 16'd1, 16'hFFFF,
                     48'd1230, 1'b1);
        send_request(lpp_pkg::MODE_TICK, 16'h0000, 16'h0000, 48'd1240, 1'b1);
        // Clear enable through the low status byte, keep it through the high byte
        send_request(lpp_pkg::MODE_WRITE_BYTE, lpp_pkg::STATUS_ADDRESS_DEF, 16'hFF00,
                     48'd1250, 1'b1);
        send_request(lpp_pkg::MODE_WRITE_BYTE, lpp_pkg::STATUS_ADDRESS_DEF | 16'd1, 16'hFFFF,
                     48'd1260, 1'b1);
        // Unmapped addresses and undecoded kinds
        send_request(lpp_pkg::MODE_READ_BYTE, 16'hFFFF, 16'hFFFF, 48'd1270, 1'b1);
        send_request(lpp_pkg::MODE_WRITE_WORD, 16'h0000, 16'hFFFF, 48'd1280, 1'b1);
        send_request(MODE_SPARE_6, lpp_pkg::STATUS_ADDRESS_DEF, 16'hFFFF, 48'd1290, 1'b1);
        send_request(MODE_SPARE_7, lpp_pkg::BUFFER_ADDRESS_DEF, 16'hFFFF, 48'd1300, 1'b1);
        // Deadline saturates near the top of the count, then done with enable set
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::BUFFER_ADDRESS_DEF, 16'h007F,
                     INSTR_MAX - 48'd5, 1'b1);
        send_request(lpp_pkg::MODE_WRITE_WORD, lpp_pkg::STATUS_ADDRESS_DEF, 16'hFFFF,
                     INSTR_MAX, 1'b1);
        send_request(lpp_pkg::MODE_TICK, 16'hFFFF, 16'hFFFF, INSTR_MAX, 1'b1);

        run_phase(16'd0, 0, 0);
        run_phase(16'hFFFF, 57, 0);
        run_phase(16'($urandom_range(2, 65534)), 0, 57);
        run_phase(16'd1, 25, 25);

        drain();
        if (fail_count == 0) begin
            $display("line_printer_port: match");
        end else begin
            $display("line_printer_port: mismatch");
        end
        $finish;
    end

endmodule
